// ----- rtl/mfw_pkg.sv -----
// ----------------------------------------------------------------------------
// Mitchell filter weight package
// Shared widths, register indexes, pipeline control type and the helper
// functions for the cubic coefficients and Q.14 rounding.
// ----------------------------------------------------------------------------
package mfw_pkg;

    localparam int OFF_W      = 16;
    localparam int INV_W      = 16;
    localparam int COEF_W     = 15;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int WEIGHT_W   = 16;

    localparam int A_W        = 32;
    localparam int T_W        = 15;
    localparam int TF_W       = A_W - 11;
    localparam int K_W        = 23;
    localparam int P_W        = 26;
    localparam int RECIP_W    = 26;
    localparam int MQ_W       = P_W + RECIP_W;
    localparam int Q_W        = 23;
    localparam int W_W        = 24;
    localparam int PROD_W     = 2 * W_W;

    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] RECIP_SIX = RECIP_W'(44739243);

    localparam logic [T_W-1:0] ONE_T = T_W'(16384);
    localparam logic [A_W-1:0] T_ROUND = A_W'(1024);

    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = 16'sh7FFF;
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = 16'sh8000;

    localparam int AXIS_STAGES = 6;
    localparam int NUM_STAGES  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_B_COEF = 2'd0,
        CFG_C_COEF = 2'd1,
        CFG_INV_X  = 2'd2,
        CFG_INV_Y  = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        TERM_K3 = 2'd0,
        TERM_K2 = 2'd1,
        TERM_K1 = 2'd2,
        TERM_K0 = 2'd3
    } term_t;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
        logic [NUM_STAGES-1:0] valid;
        logic                  in_stall;
    } pipe_ctrl_t;

    // Coefficients are six times the published ones, in Q.14.
    function automatic logic signed [K_W-1:0] cubic_coef(
        input logic              outer,
        input term_t             term,
        input logic [COEF_W-1:0] b,
        input logic [COEF_W-1:0] c
    );
        logic signed [K_W-1:0] bs;
        logic signed [K_W-1:0] cs;
        logic signed [K_W-1:0] k;
        bs = K_W'($signed({1'b0, b}));
        cs = K_W'($signed({1'b0, c}));
        k  = '0;
        if (outer)
        begin
            unique case (term)
                TERM_K3: k = K_W'(-bs - 6 * cs);
                TERM_K2: k = K_W'(6 * bs + 30 * cs);
                TERM_K1: k = K_W'(-12 * bs - 48 * cs);
                TERM_K0: k = K_W'(8 * bs + 24 * cs);
            endcase
        end
        else
        begin
            unique case (term)
                TERM_K3: k = K_W'(12 * 16384 - 9 * bs - 6 * cs);
                TERM_K2: k = K_W'(-18 * 16384 + 12 * bs + 6 * cs);
                TERM_K1: k = '0;
                TERM_K0: k = K_W'(6 * 16384 - 2 * bs);
            endcase
        end
        return k;
    endfunction

    // Divide by 2^14, rounding halves away from zero.
    function automatic logic signed [63:0] round_q14(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] q;
        mag = v[63] ? 64'(-v) : 64'(v);
        q   = (mag + 64'd8192) >> 14;
        return v[63] ? $signed(-q) : $signed(q);
    endfunction

endpackage

// ----- rtl/mfw_pipe.sv -----
// ----------------------------------------------------------------------------
// Pipeline control
// Valid bits for every stage and the per-stage load enables. A stage loads
// when it is empty or when the stage after it is loading, so bubbles close up.
// ----------------------------------------------------------------------------
module mfw_pipe
    import mfw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       out_stall,
    output pipe_ctrl_t ctrl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;

    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !out_stall;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            ready[i] = !valid_reg[i] || ready[i+1];
        end
    end

    always_comb
    begin
        valid_next[0] = ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = ready[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctrl.load     = ready;
    assign ctrl.valid    = valid_reg;
    assign ctrl.in_stall = !ready[0];

endmodule

// ----- rtl/mfw_axis.sv -----
// ----------------------------------------------------------------------------
// Axis cubic
// Six-stage datapath for one axis: scaled argument, three Horner steps and
// the rounded division by six.
// ----------------------------------------------------------------------------
module mfw_axis
    import mfw_pkg::*;
(
    input  logic                       clk,
    input  logic [AXIS_STAGES-1:0]     en,
    input  logic signed [OFF_W-1:0]    offset,
    input  logic [COEF_W-1:0]          b_coef,
    input  logic [COEF_W-1:0]          c_coef,
    input  logic [INV_W-1:0]           inv_radius,
    output logic signed [W_W-1:0]      axis_weight
);

    // Stage 1
    logic [OFF_W:0]   off_neg;
    logic [OFF_W-1:0] mag;
    logic [A_W-1:0]   a_next;
    logic [A_W-1:0]   a_reg;

    // Stage 2
    logic [A_W-1:0]              t_sum;
    logic [TF_W-1:0]             t_full;
    logic [T_W-1:0]              t2_next;
    logic                        outer2_next;
    logic                        far2_next;
    logic signed [K_W+T_W:0]     prod1_next;
    logic signed [K_W+T_W:0]     prod1_reg;
    logic [T_W-1:0]              t2_reg;
    logic                        outer2_reg;
    logic                        far2_reg;

    // Stage 3
    logic signed [P_W-1:0]       p1;
    logic signed [P_W+T_W:0]     prod2_next;
    logic signed [P_W+T_W:0]     prod2_reg;
    logic [T_W-1:0]              t3_reg;
    logic                        outer3_reg;
    logic                        far3_reg;

    // Stage 4
    logic signed [P_W-1:0]       p2;
    logic signed [P_W+T_W:0]     prod3_next;
    logic signed [P_W+T_W:0]     prod3_reg;
    logic                        outer4_reg;
    logic                        far4_reg;

    // Stage 5
    logic signed [P_W-1:0]       p3;
    logic [P_W-1:0]              mag3;
    logic [P_W-1:0]              m3;
    logic [MQ_W-1:0]             prodq_next;
    logic [MQ_W-1:0]             prodq_reg;
    logic                        neg5_reg;
    logic                        far5_reg;

    // Stage 6
    logic [Q_W-1:0]              q;
    logic signed [W_W-1:0]       q_ext;
    logic signed [W_W-1:0]       w_next;
    logic signed [W_W-1:0]       w_reg;

    always_comb
    begin
        off_neg = -{offset[OFF_W-1], offset};
        mag     = offset[OFF_W-1] ? off_neg[OFF_W-1:0] : offset;
        a_next  = A_W'(mag) * A_W'(inv_radius);
    end

    always_comb
    begin
        t_sum       = a_reg + T_ROUND;
        t_full      = t_sum[A_W-1:11];
        far2_next   = |t_full[TF_W-1:T_W];
        t2_next     = t_full[T_W-1:0];
        outer2_next = t2_next > ONE_T;
        prod1_next  = cubic_coef(outer2_next, TERM_K3, b_coef, c_coef)
                      * $signed({1'b0, t2_next});
    end

    always_comb
    begin
        p1 = P_W'(round_q14(64'(prod1_reg)))
             + P_W'(cubic_coef(outer2_reg, TERM_K2, b_coef, c_coef));
        prod2_next = p1 * $signed({1'b0, t2_reg});
    end

    always_comb
    begin
        p2 = P_W'(round_q14(64'(prod2_reg)))
             + P_W'(cubic_coef(outer3_reg, TERM_K1, b_coef, c_coef));
        prod3_next = p2 * $signed({1'b0, t3_reg});
    end

    // Division by six uses a reciprocal that is exact for magnitudes below 2^25.
    always_comb
    begin
        p3 = P_W'(round_q14(64'(prod3_reg)))
             + P_W'(cubic_coef(outer4_reg, TERM_K0, b_coef, c_coef));
        mag3       = p3[P_W-1] ? P_W'(-p3) : P_W'(p3);
        m3         = mag3 + P_W'(3);
        prodq_next = MQ_W'(m3) * MQ_W'(RECIP_SIX);
    end

    always_comb
    begin
        q      = prodq_reg[RECIP_SHIFT +: Q_W];
        q_ext  = $signed({1'b0, q});
        w_next = far5_reg ? '0 : (neg5_reg ? -q_ext : q_ext);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg <= a_next;
        end
        if (en[1])
        begin
            prod1_reg  <= prod1_next;
            t2_reg     <= t2_next;
            outer2_reg <= outer2_next;
            far2_reg   <= far2_next;
        end
        if (en[2])
        begin
            prod2_reg  <= prod2_next;
            t3_reg     <= t2_reg;
            outer3_reg <= outer2_reg;
            far3_reg   <= far2_reg;
        end
        if (en[3])
        begin
            prod3_reg  <= prod3_next;
            outer4_reg <= outer3_reg;
            far4_reg   <= far3_reg;
        end
        if (en[4])
        begin
            prodq_reg <= prodq_next;
            neg5_reg  <= p3[P_W-1];
            far5_reg  <= far4_reg;
        end
        if (en[5])
        begin
            w_reg <= w_next;
        end
    end

    assign axis_weight = w_reg;

endmodule

// ----- rtl/mitchell_filter_weight_2d_core.sv -----
// Path: an input transfer goes through the axis stages, then the product and
// weight registers, before the weight is offered.
// Throughput: one item per cycle, set by the eight-stage pipeline, unless stalled.
// Reset: asynchronous, active low; it empties the pipeline and loads the
// default B, C and inverse radii.
// ----------------------------------------------------------------------------
// Mitchell-Netravali filter weight core
// Separable 2D filter weight: two axis cubic pipelines, their product and
// rounding with saturation to signed Q2.14.
// ----------------------------------------------------------------------------
module mitchell_filter_weight_2d_core
    import mfw_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [OFF_W-1:0]     offset_x,
    input  logic signed [OFF_W-1:0]     offset_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [WEIGHT_W-1:0]  weight
);

    logic [COEF_W-1:0] b_coef_reg;
    logic [COEF_W-1:0] b_coef_next;
    logic [COEF_W-1:0] c_coef_reg;
    logic [COEF_W-1:0] c_coef_next;
    logic [INV_W-1:0]  inv_x_reg;
    logic [INV_W-1:0]  inv_x_next;
    logic [INV_W-1:0]  inv_y_reg;
    logic [INV_W-1:0]  inv_y_next;

    pipe_ctrl_t ctrl;

    logic signed [W_W-1:0]      wx;
    logic signed [W_W-1:0]      wy;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [63:0]         rounded;
    logic signed [WEIGHT_W-1:0] weight_next;
    logic signed [WEIGHT_W-1:0] weight_reg;

    always_comb
    begin
        b_coef_next = b_coef_reg;
        c_coef_next = c_coef_reg;
        inv_x_next  = inv_x_reg;
        inv_y_next  = inv_y_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_B_COEF: b_coef_next = cfg_data[COEF_W-1:0];
                CFG_C_COEF: c_coef_next = cfg_data[COEF_W-1:0];
                CFG_INV_X:  inv_x_next  = cfg_data[INV_W-1:0];
                CFG_INV_Y:  inv_y_next  = cfg_data[INV_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_coef_reg <= COEF_W'(5461);
            c_coef_reg <= COEF_W'(5461);
            inv_x_reg  <= INV_W'(8192);
            inv_y_reg  <= INV_W'(8192);
        end
        else
        begin
            b_coef_reg <= b_coef_next;
            c_coef_reg <= c_coef_next;
            inv_x_reg  <= inv_x_next;
            inv_y_reg  <= inv_y_next;
        end
    end

    mfw_pipe u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .ctrl      (ctrl)
    );

    mfw_axis u_axis_x (
        .clk         (clk),
        .en          (ctrl.load[AXIS_STAGES-1:0]),
        .offset      (offset_x),
        .b_coef      (b_coef_reg),
        .c_coef      (c_coef_reg),
        .inv_radius  (inv_x_reg),
        .axis_weight (wx)
    );

    mfw_axis u_axis_y (
        .clk         (clk),
        .en          (ctrl.load[AXIS_STAGES-1:0]),
        .offset      (offset_y),
        .b_coef      (b_coef_reg),
        .c_coef      (c_coef_reg),
        .inv_radius  (inv_y_reg),
        .axis_weight (wy)
    );

    always_comb
    begin
        prod_next = PROD_W'(wx) * PROD_W'(wy);
    end

    always_comb
    begin
        rounded = round_q14(64'(prod_reg));
        priority if (rounded > 64'(WEIGHT_MAX))
        begin
            weight_next = WEIGHT_MAX;
        end
        else if (rounded < 64'(WEIGHT_MIN))
        begin
            weight_next = WEIGHT_MIN;
        end
        else
        begin
            weight_next = rounded[WEIGHT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[AXIS_STAGES])
        begin
            prod_reg <= prod_next;
        end
        if (ctrl.load[NUM_STAGES-1])
        begin
            weight_reg <= weight_next;
        end
    end

    assign in_stall  = ctrl.in_stall;
    assign out_valid = ctrl.valid[NUM_STAGES-1];
    assign weight    = weight_reg;

`ifndef SYNTHESIS
    // The input is held off only when every stage holds an item.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (&ctrl.valid)
    ) else $error("input stalled while the pipeline has an empty stage");

    // A transfer at the output always frees room for a new input.
    a_drain_frees_input: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall
    ) else $error("input stalled although the output is not stalled");

    // A new output only appears when the stage before it was occupied.
    a_output_from_product: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(ctrl.valid[NUM_STAGES-2])
    ) else $error("output became valid without a product in flight");
`endif

endmodule
